// File: rtl/pst_pkg.sv
package pst_pkg;

    localparam int Y_BITS       = 16;
    localparam int MAX_VERSIONS = 1024;
    localparam int NODE_POOL    = 17408;
    localparam int VER_AW       = $clog2(MAX_VERSIONS);
    localparam int NODE_AW      = $clog2(NODE_POOL);
    localparam int LINK_W       = 16;
    localparam int LVL_W        = $clog2(Y_BITS + 1);

    localparam logic [LINK_W-1:0] NO_LINK = '1;

    typedef enum logic [1:0] {
        ACT_PUSH  = 2'd0,
        ACT_QUERY = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        t_action            action;
        logic [15:0]        y_position;
        logic signed [31:0] y_amount;
        logic [9:0]         version_low;
        logic [9:0]         version_high;
        logic [15:0]        range_low;
        logic [15:0]        range_high;
    } t_in;

    typedef struct packed {
        logic signed [63:0] range_sum;
        logic [1:0]         status;
        logic [10:0]        version_count;
    } t_out;

    typedef struct packed {
        logic [LINK_W-1:0] left;
        logic [LINK_W-1:0] right;
        logic [63:0]       sum;
    } t_node;

endpackage

// File: rtl/pst_ram.sv
module pst_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: rtl/persistent_segment_tree_range_sum.sv
// channel  | signals                | direction | accepted when
// ---------+------------------------+-----------+------------------------
// command  | start, busy, i_item    | in        | start high, busy low
// result   | o_done, o_item         | out       | o_done high (one cycle)
//
// push: writes one new node per tree level, from root to leaf
// query: up to four prefix walks over the node memory; clear, rejected and empty
//   items are answered straight from the idle state
// reset clears the state, the done flag and the version and node counts; memories hold no reset value
// the receiver cannot stall: o_done flags each result for one cycle
module persistent_segment_tree_range_sum (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         start,
    output logic         busy,
    input  pst_pkg::t_in i_item,
    output logic         o_done,
    output pst_pkg::t_out o_item
);
    import pst_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_P_ROOT,
        S_P_WALK,
        S_Q_SEL,
        S_Q_ROOT,
        S_Q_WALK
    } t_state;

    t_state r_state, n_state;

    logic [10:0]        r_vers, n_vers;
    logic [NODE_AW-1:0] r_nodes, n_nodes;
    logic [NODE_AW-1:0] r_cur, n_cur;
    logic [LVL_W-1:0]   r_lvl, n_lvl;
    logic [Y_BITS-1:0]  r_key, n_key;
    logic [63:0]        r_amt, n_amt;
    logic               r_pok, n_pok;
    logic [63:0]        r_sum, n_sum;
    logic [1:0]         r_walk, n_walk;
    logic               r_arr, n_arr;
    logic [Y_BITS-1:0]  r_kb, n_kb;
    logic [Y_BITS-1:0]  r_ka, n_ka;
    logic [VER_AW-1:0]  r_th, n_th;
    logic [VER_AW-1:0]  r_tl, n_tl;
    logic               r_ena, n_ena;
    logic               r_enl, n_enl;
    logic               r_done, n_done;
    t_out               r_out, n_out;

    // memory ports
    logic               root_we;
    logic [VER_AW-1:0]  root_waddr, root_raddr;
    logic [NODE_AW-1:0] root_wdata, root_rdata;
    logic               node_we;
    logic [NODE_AW-1:0] node_waddr, node_raddr;
    t_node              node_wdata, node_rdata;

    pst_ram #(.W(NODE_AW), .D(MAX_VERSIONS)) u_root (
        .i_clk  (i_clk),
        .i_we   (root_we),
        .i_waddr(root_waddr),
        .i_wdata(root_wdata),
        .i_raddr(root_raddr),
        .o_rdata(root_rdata)
    );

    pst_ram #(.W($bits(t_node)), .D(NODE_POOL)) u_node (
        .i_clk  (i_clk),
        .i_we   (node_we),
        .i_waddr(node_waddr),
        .i_wdata(node_wdata),
        .i_raddr(node_raddr),
        .o_rdata(node_rdata)
    );

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_item = r_out;

    t_node              prev_node;
    logic               leaf, bit_now, take;
    logic [LINK_W-1:0]  nxt;
    logic [63:0]        delta;
    logic               neg;
    logic               walk_en;
    logic               pool_full;

    always_comb begin
        n_state = r_state;
        n_vers  = r_vers;
        n_nodes = r_nodes;
        n_cur   = r_cur;
        n_lvl   = r_lvl;
        n_key   = r_key;
        n_amt   = r_amt;
        n_pok   = r_pok;
        n_sum   = r_sum;
        n_walk  = r_walk;
        n_arr   = r_arr;
        n_kb    = r_kb;
        n_ka    = r_ka;
        n_th    = r_th;
        n_tl    = r_tl;
        n_ena   = r_ena;
        n_enl   = r_enl;
        n_done  = 1'b0;
        n_out   = r_out;

        root_we    = 1'b0;
        root_waddr = r_vers[VER_AW-1:0];
        root_wdata = r_nodes;
        root_raddr = VER_AW'(r_vers - 11'd1);
        node_we    = 1'b0;
        node_waddr = r_cur;
        node_raddr = root_rdata;

        leaf      = (r_lvl == LVL_W'(Y_BITS));
        bit_now   = r_key[Y_BITS-1];
        prev_node = r_pok ? node_rdata :
                    t_node'{left: NO_LINK, right: NO_LINK, sum: 64'd0};
        nxt       = NO_LINK;
        take      = leaf | bit_now;
        neg       = (r_walk == 2'd1) || (r_walk == 2'd2);
        delta     = take ? node_rdata.sum : (64'd0 - node_rdata.sum);
        pool_full = (r_vers >= 11'(MAX_VERSIONS)) ||
                    ((17'(r_nodes) + 17'(Y_BITS + 1)) > 17'(NODE_POOL));
        walk_en   = 1'b1;
        case (r_walk)
            2'd1:    walk_en = r_ena;
            2'd2:    walk_en = r_enl;
            2'd3:    walk_en = r_ena & r_enl;
            default: walk_en = 1'b1;
        endcase

        node_wdata.sum   = prev_node.sum + r_amt;
        node_wdata.left  = NO_LINK;
        node_wdata.right = NO_LINK;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_out.range_sum     = 64'sd0;
                    n_out.status        = ST_OK;
                    n_out.version_count = r_vers;
                    case (i_item.action)
                        ACT_PUSH: begin
                            if (pool_full) begin
                                n_out.status = ST_FULL;
                                n_done       = 1'b1;
                            end else begin
                                // new root is the first node of this path
                                root_we = 1'b1;
                                n_cur   = r_nodes;
                                n_key   = i_item.y_position[Y_BITS-1:0];
                                n_amt   = {{32{i_item.y_amount[31]}}, i_item.y_amount};
                                n_lvl   = '0;
                                n_pok   = 1'b0;
                                n_state = (r_vers == 11'd0) ? S_P_WALK : S_P_ROOT;
                            end
                        end
                        ACT_QUERY: begin
                            if ((i_item.version_low > i_item.version_high) ||
                                (11'(i_item.version_high) >= r_vers)) begin
                                n_out.status = ST_RANGE;
                                n_done       = 1'b1;
                            end else if (i_item.range_low > i_item.range_high) begin
                                n_done = 1'b1;
                            end else begin
                                // sum = P(h,b) - P(h,a-1) - P(l-1,b) + P(l-1,a-1)
                                n_kb    = i_item.range_high[Y_BITS-1:0];
                                n_ka    = i_item.range_low[Y_BITS-1:0] - Y_BITS'(1);
                                n_ena   = (i_item.range_low != 16'd0);
                                n_th    = i_item.version_high;
                                n_tl    = i_item.version_low - VER_AW'(1);
                                n_enl   = (i_item.version_low != 10'd0);
                                n_walk  = 2'd0;
                                n_sum   = 64'd0;
                                n_state = S_Q_SEL;
                            end
                        end
                        ACT_CLEAR: begin
                            n_vers              = 11'd0;
                            n_nodes             = '0;
                            n_out.version_count = 11'd0;
                            n_done              = 1'b1;
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            S_P_ROOT: begin
                // previous version root arrives, fetch it
                node_raddr = root_rdata;
                n_pok      = (17'(root_rdata) < 17'(NODE_POOL));
                n_state    = S_P_WALK;
            end
            S_P_WALK: begin
                // new node never collides with the old node read in the same cycle
                node_we = 1'b1;
                if (leaf) begin
                    n_vers                    = r_vers + 11'd1;
                    n_nodes                   = r_nodes + NODE_AW'(Y_BITS + 1);
                    n_out.range_sum           = 64'sd0;
                    n_out.status              = ST_OK;
                    n_out.version_count       = r_vers + 11'd1;
                    n_done                    = 1'b1;
                    n_state                   = S_IDLE;
                end else begin
                    if (bit_now) begin
                        node_wdata.right = LINK_W'(r_cur + NODE_AW'(1));
                        node_wdata.left  = prev_node.left;
                        nxt              = prev_node.right;
                    end else begin
                        node_wdata.left  = LINK_W'(r_cur + NODE_AW'(1));
                        node_wdata.right = prev_node.right;
                        nxt              = prev_node.left;
                    end
                    node_raddr = nxt[NODE_AW-1:0];
                    n_pok      = (nxt < LINK_W'(NODE_POOL));
                    n_cur      = r_cur + NODE_AW'(1);
                    n_lvl      = r_lvl + LVL_W'(1);
                    n_key      = r_key << 1;
                end
            end
            S_Q_SEL: begin
                root_raddr = r_walk[1] ? r_tl : r_th;
                if (walk_en) begin
                    n_key   = r_walk[0] ? r_ka : r_kb;
                    n_state = S_Q_ROOT;
                end else if (r_walk == 2'd3) begin
                    n_out.range_sum     = r_sum;
                    n_out.status        = ST_OK;
                    n_out.version_count = r_vers;
                    n_done              = 1'b1;
                    n_state             = S_IDLE;
                end else begin
                    n_walk = r_walk + 2'd1;
                end
            end
            S_Q_ROOT: begin
                node_raddr = root_rdata;
                n_lvl      = '0;
                n_arr      = 1'b0;
                if (17'(root_rdata) < 17'(NODE_POOL)) begin
                    n_state = S_Q_WALK;
                end else if (r_walk == 2'd3) begin
                    n_out.range_sum     = r_sum;
                    n_out.status        = ST_OK;
                    n_out.version_count = r_vers;
                    n_done              = 1'b1;
                    n_state             = S_IDLE;
                end else begin
                    n_walk  = r_walk + 2'd1;
                    n_state = S_Q_SEL;
                end
            end
            S_Q_WALK: begin
                // prefix walk: add node when turning right or at leaf,
                // subtract a node reached by a right turn
                if (take != r_arr) begin
                    n_sum = neg ? (r_sum - delta) : (r_sum + delta);
                end
                nxt        = bit_now ? node_rdata.right : node_rdata.left;
                node_raddr = nxt[NODE_AW-1:0];
                if (leaf || (nxt >= LINK_W'(NODE_POOL))) begin
                    if (r_walk == 2'd3) begin
                        n_out.range_sum     = (take != r_arr) ?
                                              (neg ? (r_sum - delta) : (r_sum + delta)) : r_sum;
                        n_out.status        = ST_OK;
                        n_out.version_count = r_vers;
                        n_done              = 1'b1;
                        n_state             = S_IDLE;
                    end else begin
                        n_walk  = r_walk + 2'd1;
                        n_state = S_Q_SEL;
                    end
                end else begin
                    n_lvl = r_lvl + LVL_W'(1);
                    n_key = r_key << 1;
                    n_arr = bit_now;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_vers  <= 11'd0;
            r_nodes <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_vers  <= n_vers;
            r_nodes <= n_nodes;
            r_done  <= n_done;
        end
        r_cur  <= n_cur;
        r_lvl  <= n_lvl;
        r_key  <= n_key;
        r_amt  <= n_amt;
        r_pok  <= n_pok;
        r_sum  <= n_sum;
        r_walk <= n_walk;
        r_arr  <= n_arr;
        r_kb   <= n_kb;
        r_ka   <= n_ka;
        r_th   <= n_th;
        r_tl   <= n_tl;
        r_ena  <= n_ena;
        r_enl  <= n_enl;
        r_out  <= n_out;
    end
endmodule
